// File: sv/pcv_pkg.sv
// Shared types and constants of the PKCS #1 v1.5 padding checker.
`default_nettype none
package pcv_pkg;

  localparam int MAX_BLOCK_BYTES = 512;
  localparam int PAD_MIN_BYTES   = 8;
  localparam int LEN_W           = 10;
  localparam int PLEN_W          = 9;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(128);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_BLOCK_BYTES);
  localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(3 + PAD_MIN_BYTES);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_LEAD    = 3'd2;
  localparam logic [2:0] ST_TYPE    = 3'd3;
  localparam logic [2:0] ST_NOSTART = 3'd4;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_SEARCH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_FAILED  = 4'b1000
  } phase_t;

  // One classified input word: an optional payload byte and an optional status.
  typedef struct packed {
    logic              emit;
    logic              final_byte;
    logic [7:0]        data;
    logic [2:0]        status;
    logic [PLEN_W-1:0] plen;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/pcv_front.sv
// Front end: length register, block state and per-byte classification.
`default_nettype none
module pcv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [9:0]        cfg_wr_data,
  input  logic              take,
  input  logic [7:0]        block_byte,
  output pcv_pkg::cmd_t     cmd,
  output logic              cmd_push
);
  import pcv_pkg::*;

  logic [LEN_W-1:0] block_length;
  logic [LEN_W-1:0] byte_position;
  phase_t           phase;
  logic [1:0]       block_type;
  logic [2:0]       error_code;
  logic [LEN_W-1:0] payload_count;

  phase_t           phase_next;
  logic [1:0]       block_type_next;
  logic [2:0]       error_code_next;
  logic [LEN_W-1:0] payload_count_next;
  logic [LEN_W-1:0] len;
  logic [LEN_W:0]   pos_inc;
  logic [LEN_W:0]   pos_inc2;
  logic             final_byte;
  logic             too_short;
  logic             emit;
  logic [2:0]       st;

  always_comb begin
    len        = (block_length > LEN_MAX) ? LEN_MAX : block_length;
    pos_inc    = {1'b0, byte_position} + (LEN_W+1)'(1);
    pos_inc2   = {1'b0, byte_position} + (LEN_W+1)'(2);
    final_byte = (pos_inc >= {1'b0, len});
    too_short  = (len <= LEN_SHORT);

    phase_next      = phase;
    block_type_next = block_type;
    error_code_next = error_code;
    emit            = 1'b0;

    if (!too_short) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_position == '0) begin
            if (block_byte != 8'd0) begin
              error_code_next = ST_LEAD;
              phase_next      = PH_FAILED;
            end
          end else if (block_byte > 8'd2) begin
            error_code_next = ST_TYPE;
            phase_next      = PH_FAILED;
          end else begin
            block_type_next = block_byte[1:0];
            phase_next      = PH_SEARCH;
          end
        end
        PH_SEARCH: begin
          if (block_type == 2'd0) begin
            if (block_byte != 8'd0) begin
              phase_next = PH_PAYLOAD;
              emit       = 1'b1;
            end
          end else if (block_byte == 8'd0 && pos_inc2 <= {1'b0, len}) begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: emit = 1'b1;
        PH_FAILED:  ;
        default:    ;
      endcase
    end

    payload_count_next = payload_count + LEN_W'(emit);

    if (too_short)                     st = ST_SHORT;
    else if (phase_next == PH_PAYLOAD) st = ST_OK;
    else if (phase_next == PH_FAILED)  st = error_code_next;
    else                               st = ST_NOSTART;

    cmd.emit       = emit;
    cmd.final_byte = final_byte;
    cmd.data       = block_byte;
    cmd.status     = st;
    cmd.plen       = (st == ST_OK) ? payload_count_next[PLEN_W-1:0] : '0;
    cmd_push       = take && (emit || final_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= LEN_RESET;
    end else if (cfg_wr_en) begin
      block_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      phase         <= PH_HEADER;
      block_type    <= '0;
      error_code    <= ST_OK;
      payload_count <= '0;
    end else if (take) begin
      if (final_byte) begin
        byte_position <= '0;
        phase         <= PH_HEADER;
        block_type    <= '0;
        error_code    <= ST_OK;
        payload_count <= '0;
      end else begin
        byte_position <= pos_inc[LEN_W-1:0];
        phase         <= phase_next;
        block_type    <= block_type_next;
        error_code    <= error_code_next;
        payload_count <= payload_count_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/pcv_fifo.sv
// Short show-ahead queue of classified words between front and back end.
`default_nettype none
module pcv_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcv_pkg::cmd_t wdata,
  input  logic          pop,
  output pcv_pkg::cmd_t rdata,
  output logic          rvalid,
  output logic          full
);
  import pcv_pkg::*;

  cmd_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign rdata  = entries[rd_ptr];
  assign rvalid = (count != '0);
  assign full   = (count == FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      if (push && !pop)      count <= count + FIFO_CNT_W'(1);
      else if (pop && !push) count <= count - FIFO_CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: sv/pcv_back.sv
// Back end: expands each queued word into its results and holds the output.
`default_nettype none
module pcv_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  pcv_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_status,
  output logic [7:0]                 payload_byte,
  output logic [2:0]                 status,
  output logic [pcv_pkg::PLEN_W-1:0] payload_length,
  output logic                       last
);
  import pcv_pkg::*;

  cmd_t cur;
  logic cur_valid;
  logic sent;
  logic show_payload;
  logic finishing;
  logic load;

  always_comb begin
    show_payload   = cur.emit && !sent;
    finishing      = cur_valid && out_ready && (!show_payload || !cur.final_byte);
    load           = !cur_valid || finishing;
    q_pop          = load && q_valid;

    out_valid      = cur_valid;
    is_status      = !show_payload;
    payload_byte   = show_payload ? cur.data : 8'd0;
    status         = show_payload ? ST_OK : cur.status;
    payload_length = show_payload ? '0 : cur.plen;
    last           = show_payload ? !cur.final_byte : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sent      <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      sent      <= 1'b0;
    end else if (finishing) begin
      cur_valid <= 1'b0;
      sent      <= 1'b0;
    end else if (cur_valid && out_ready && show_payload) begin
      sent      <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: sv/pkcs1_v15_pad_checker_unit.sv
// Top level of the streaming PKCS #1 v1.5 padding checker.
//
// Usage:
//   Feed the bytes of a decrypted block on in_valid/in_ready/block_byte,
//   byte zero first; each accepted word is one byte. cfg_wr_en/cfg_wr_data
//   set the block length (reset 128, saturated at 512); write it while idle.
//   Results leave on out_valid/out_ready: payload words (is_status 0) as
//   soon as the payload start is known, and one status word on the final
//   byte of each block, with payload_length on an ok status. last marks
//   the final result caused by one input byte.
// Timing:
//   One byte per cycle is accepted while the queue has room. A result is
//   registered in the queue and then in the output stage before it is
//   offered; the back end delivers one result per cycle while out_ready is
//   high, so a final byte that also carries payload gives two results.
//   A four-word queue sits between the classifier and the output stage.
// Reset:
//   rst (synchronous) restores the block length to 128, restarts at byte
//   zero and empties the queue; no results are pending afterwards.
// Stall:
//   A stalled receiver holds the output word; the front keeps taking bytes
//   until the queue fills, then drops in_ready.
`default_nettype none
module pkcs1_v15_pad_checker_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [9:0]                 cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 block_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_status,
  output logic [7:0]                 payload_byte,
  output logic [2:0]                 status,
  output logic [pcv_pkg::PLEN_W-1:0] payload_length,
  output logic                       last
);
  import pcv_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic front_push;
  logic q_valid;
  logic q_pop;
  logic q_full;
  logic take;

  // Accept whenever the queue has room, whatever the byte turns out to be.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  pcv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .block_byte  (block_byte),
    .cmd         (front_cmd),
    .cmd_push    (front_push)
  );

  // Bytes that cause no result never enter the queue.
  pcv_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (front_push),
    .wdata  (front_cmd),
    .pop    (q_pop),
    .rdata  (q_cmd),
    .rvalid (q_valid),
    .full   (q_full)
  );

  pcv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_status      (is_status),
    .payload_byte   (payload_byte),
    .status         (status),
    .payload_length (payload_length),
    .last           (last)
  );

  // A payload word that is not last is always followed by its status word.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !is_status && !last) |=> (out_valid && is_status))
    else $error("status word missing after final payload byte");

  // A full queue implies the output stage holds work.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("queue full while output stage idle");

  // A failing status never reports a payload length.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_status && status != ST_OK) |-> (payload_length == '0))
    else $error("payload length on failing status");

endmodule
`default_nettype wire
